[design/spmb_pkg.sv]
// Shared types, constants and the log table builder for the stereo peak meter.
// No dependencies; every other file of the meter imports this package.
package spmb_pkg;

    localparam int LogTableBitsDefault = 6;

    // dB per octave (6.0206) in Q16, level scale 1/256 dB after the >> 24
    localparam int DbPerLog2Q16 = 394568;
    localparam logic signed [17:0] LEVEL_MAX = 18'sd10240;

    localparam logic signed [15:0] FLOOR_RESET   = -16'sd15360;
    localparam logic signed [15:0] CLIP_RESET    = 16'sd0;
    localparam logic signed [15:0] MARKER_RESET  = -16'sd1536;
    localparam logic [15:0]        RELEASE_RESET = 16'd1311;
    localparam logic [23:0]        HOLD_RESET    = 24'd256000;

    localparam logic [1:0] ZONE_GREEN  = 2'd0;
    localparam logic [1:0] ZONE_YELLOW = 2'd1;
    localparam logic [1:0] ZONE_RED    = 2'd2;

    localparam int RegIdxBits = 3;
    localparam logic [RegIdxBits-1:0] REG_FLOOR   = 3'd0;
    localparam logic [RegIdxBits-1:0] REG_CLIP    = 3'd1;
    localparam logic [RegIdxBits-1:0] REG_MARKER  = 3'd2;
    localparam logic [RegIdxBits-1:0] REG_RELEASE = 3'd3;
    localparam logic [RegIdxBits-1:0] REG_HOLD    = 3'd4;

    typedef struct packed {
        logic [31:0] peak_left;
        logic [31:0] peak_right;
        logic [15:0] elapsed_time;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] level_left;
        logic signed [15:0] level_right;
        logic [1:0]         zone_left;
        logic [1:0]         zone_right;
        logic               clip_left;
        logic               clip_right;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] floor_level;
        logic signed [15:0] clip_threshold;
        logic signed [15:0] marker_level;
        logic [15:0]        release_rate;
        logic [23:0]        clip_hold_time;
    } cfg_t;

    // stage load strobes of the three-stage pipeline
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctrl_t;

    // log2(1 + i/2^bits) in Q16, by repeated squaring in Q1.30
    function automatic logic [15:0] log2_frac(int unsigned i, int unsigned bits);
        logic [63:0] x;
        logic [15:0] acc;
        x   = (64'd1 << 30) + ((64'(i) << 30) >> bits);
        acc = '0;
        for (int k = 0; k < 16; k++) begin
            x   = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd2 << 30)) begin
                acc[0] = 1'b1;
                x      = x >> 1;
            end
        end
        return acc;
    endfunction

endpackage

[design/spmb_log_lane.sv]
// One channel's peak-to-dB conversion: leading-one and table log (stage 1),
// then scaling by dB per octave (stage 2). Depends on spmb_pkg.
module spmb_log_lane import spmb_pkg::*; #(
    parameter int LOG_TABLE_BITS = LogTableBitsDefault
) (
    input  logic                clk,
    input  pipe_ctrl_t          ctrl,
    input  logic [31:0]         peak,
    output logic signed [17:0]  level,
    output logic                zero
);

    localparam int TabSize = 1 << LOG_TABLE_BITS;
    localparam logic signed [19:0] DB_SCALE = 20'(DbPerLog2Q16);
    localparam logic signed [41:0] ROUND = 42'sd1 <<< 23;

    logic [15:0] tab [TabSize];

    for (genvar gi = 0; gi < TabSize; gi++) begin : g_tab
        assign tab[gi] = log2_frac(gi, LOG_TABLE_BITS);
    end

    logic [4:0]                     lead;
    logic [32+LOG_TABLE_BITS-1:0]   aligned;
    logic [LOG_TABLE_BITS-1:0]      idx;
    logic [5:0]                     octave;
    logic signed [21:0]             lg_next;
    logic signed [21:0]             lg_reg;
    logic                           zero1_reg;
    logic signed [41:0]             prod;
    logic signed [41:0]             prod_rnd;
    logic signed [17:0]             level_reg;
    logic                           zero2_reg;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (peak[i])
            begin
                lead = 5'(i);
            end
        end
    end

    // bits below the leading one, zero filled when the peak is short
    assign aligned = {peak, {LOG_TABLE_BITS{1'b0}}} >> lead;
    assign idx     = aligned[LOG_TABLE_BITS-1:0];
    assign octave  = {1'b0, lead} - 6'd16;
    assign lg_next = {octave, tab[idx]};

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            lg_reg    <= lg_next;
            zero1_reg <= (peak == 32'd0);
        end
    end

    assign prod     = lg_reg * DB_SCALE;
    assign prod_rnd = prod + ROUND;

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            level_reg <= prod_rnd[41:24];
            zero2_reg <= zero1_reg;
        end
    end

    assign level = level_reg;
    assign zero  = zero2_reg;

endmodule

[design/spmb_ballistics.sv]
// One channel's display state: clamp, instant attack / linear release,
// clip-hold countdown and colour zone. Depends on spmb_pkg.
module spmb_ballistics import spmb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  cfg_t                cfg,
    input  logic signed [17:0]  level_in,
    input  logic                zero,
    input  logic [15:0]         step,
    input  logic [15:0]         dt,
    output logic signed [15:0]  level,
    output logic [1:0]          zone,
    output logic                clip
);

    logic signed [15:0] shown_reg;
    logic signed [15:0] shown_next;
    logic [23:0]        countdown_reg;
    logic [23:0]        countdown_next;
    logic [1:0]         zone_reg;
    logic [1:0]         zone_next;

    logic signed [17:0] floor18;
    logic signed [17:0] thr18;
    logic signed [17:0] shown18;
    logic signed [17:0] upper_c;
    logic signed [17:0] lower_c;
    logic signed [17:0] peak_lvl;
    logic signed [17:0] fall;
    logic signed [17:0] fall_c;
    logic               hit;

    assign floor18 = {{2{cfg.floor_level[15]}}, cfg.floor_level};
    assign thr18   = {{2{cfg.clip_threshold[15]}}, cfg.clip_threshold};
    assign shown18 = {{2{shown_reg[15]}}, shown_reg};

    // upper bound first, so a floor above +40 dB wins
    assign upper_c  = (level_in > LEVEL_MAX) ? LEVEL_MAX : level_in;
    assign lower_c  = (upper_c < floor18) ? floor18 : upper_c;
    assign peak_lvl = zero ? floor18 : lower_c;

    assign fall   = shown18 - $signed({2'b00, step});
    assign fall_c = (fall < floor18) ? floor18 : fall;

    assign shown_next = (peak_lvl > shown18) ? peak_lvl[15:0] : fall_c[15:0];

    assign hit = (peak_lvl >= thr18);

    always_comb
    begin
        if (hit)
        begin
            countdown_next = cfg.clip_hold_time;
        end
        else if (countdown_reg > {8'd0, dt})
        begin
            countdown_next = countdown_reg - {8'd0, dt};
        end
        else
        begin
            countdown_next = '0;
        end
    end

    always_comb
    begin
        priority if (shown_next >= cfg.clip_threshold)
        begin
            zone_next = ZONE_RED;
        end
        else if (shown_next >= cfg.marker_level)
        begin
            zone_next = ZONE_YELLOW;
        end
        else
        begin
            zone_next = ZONE_GREEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg     <= FLOOR_RESET;
            countdown_reg <= '0;
            zone_reg      <= ZONE_GREEN;
        end
        else if (ctrl.load3)
        begin
            shown_reg     <= shown_next;
            countdown_reg <= countdown_next;
            zone_reg      <= zone_next;
        end
    end

    assign level = shown_reg;
    assign zone  = zone_reg;
    assign clip  = (countdown_reg != 24'd0);

    a_above_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load3 |=> shown_reg >= $past(cfg.floor_level))
        else $error("shown level below floor after update");

    a_clip_reload: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load3 && hit |=> countdown_reg == $past(cfg.clip_hold_time))
        else $error("clip countdown not reloaded on clip");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.load3 |=> $stable(shown_reg) && $stable(countdown_reg) && $stable(zone_reg))
        else $error("meter state moved without a transfer");

endmodule

[design/stereo_peak_meter_ballistics_unit.sv]
// Stereo peak meter: converts left and right linear peaks (Q16.16) to dB with
// a table log, applies instant attack, linear release and clip hold, and
// reports level, colour zone and clip LED per channel. One item is taken per
// clock cycle while the input is not stalled. Each result is presented once
// it has passed the three register stages (leading-one and log table, dB
// scaling multiplier, ballistics update). An output stall holds the pipeline,
// and the input stalls only once all three stages are full. The two channels
// run in parallel lanes. Registers sit on an APB port at byte addresses 0, 4,
// 8, 12, 16. Depends on spmb_pkg.
module stereo_peak_meter_ballistics_unit import spmb_pkg::*; #(
    parameter int LOG_TABLE_BITS = LogTableBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t               cfg_reg;
    logic [RegIdxBits-1:0] reg_idx;
    logic               wr_en;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               free1;
    logic               free2;
    logic               free3;
    pipe_ctrl_t         ctrl;

    logic [31:0]        step_prod;
    logic [15:0]        s1_step_reg;
    logic [15:0]        s1_dt_reg;
    logic [15:0]        s2_step_reg;
    logic [15:0]        s2_dt_reg;

    logic signed [17:0] lvl_l;
    logic signed [17:0] lvl_r;
    logic               zero_l;
    logic               zero_r;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_level    <= FLOOR_RESET;
            cfg_reg.clip_threshold <= CLIP_RESET;
            cfg_reg.marker_level   <= MARKER_RESET;
            cfg_reg.release_rate   <= RELEASE_RESET;
            cfg_reg.clip_hold_time <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FLOOR:   cfg_reg.floor_level    <= pwdata[15:0];
                REG_CLIP:    cfg_reg.clip_threshold <= pwdata[15:0];
                REG_MARKER:  cfg_reg.marker_level   <= pwdata[15:0];
                REG_RELEASE: cfg_reg.release_rate   <= pwdata[15:0];
                REG_HOLD:    cfg_reg.clip_hold_time <= pwdata[23:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FLOOR:   prdata = {{16{cfg_reg.floor_level[15]}}, cfg_reg.floor_level};
            REG_CLIP:    prdata = {{16{cfg_reg.clip_threshold[15]}}, cfg_reg.clip_threshold};
            REG_MARKER:  prdata = {{16{cfg_reg.marker_level[15]}}, cfg_reg.marker_level};
            REG_RELEASE: prdata = {16'd0, cfg_reg.release_rate};
            REG_HOLD:    prdata = {8'd0, cfg_reg.clip_hold_time};
            default:     prdata = '0;
        endcase
    end

    // pipeline flow: a stage loads when it is empty or its content moves on
    assign free3 = !v3_reg || !out_stall;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    assign ctrl.load1 = in_valid && free1;
    assign ctrl.load2 = v1_reg && free2;
    assign ctrl.load3 = v2_reg && free3;
    assign in_stall   = !free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // release step, shared by both lanes
    assign step_prod = cfg_reg.release_rate * in_data.elapsed_time;

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            s1_step_reg <= step_prod[31:16];
            s1_dt_reg   <= in_data.elapsed_time;
        end
        if (ctrl.load2)
        begin
            s2_step_reg <= s1_step_reg;
            s2_dt_reg   <= s1_dt_reg;
        end
    end

    spmb_log_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_left (
        .clk   (clk),
        .ctrl  (ctrl),
        .peak  (in_data.peak_left),
        .level (lvl_l),
        .zero  (zero_l)
    );

    spmb_log_lane #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_lane_right (
        .clk   (clk),
        .ctrl  (ctrl),
        .peak  (in_data.peak_right),
        .level (lvl_r),
        .zero  (zero_r)
    );

    spmb_ballistics u_bal_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .level_in (lvl_l),
        .zero     (zero_l),
        .step     (s2_step_reg),
        .dt       (s2_dt_reg),
        .level    (out_data.level_left),
        .zone     (out_data.zone_left),
        .clip     (out_data.clip_left)
    );

    spmb_ballistics u_bal_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .level_in (lvl_r),
        .zero     (zero_r),
        .step     (s2_step_reg),
        .dt       (s2_dt_reg),
        .level    (out_data.level_right),
        .zone     (out_data.zone_right),
        .clip     (out_data.clip_right)
    );

    assign out_valid = v3_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_stall && !v2_reg |=> !v3_reg)
        else $error("result repeated after transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

endmodule
